>>> rtl/htfe_pkg.sv
// Shared types and constants of the hashed transition state machine engine.
package htfe_pkg;

    localparam int KEY_W      = 16;
    localparam int REM_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int STATE_W    = 8;
    localparam int EVENT_W    = 8;
    localparam int ACT_W      = 6;
    localparam int SLOT_W     = 6;
    localparam int SIZE_W     = 7;
    localparam int STATUS_W   = 3;

    localparam logic [SIZE_W-1:0]  CFG_SIZE_RST = 7'd64;
    localparam logic [STATE_W-1:0] CFG_INIT_RST = 8'd0;
    localparam logic [EVENT_W-1:0] CFG_ERR_RST  = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_SIZE    = 2'd0,
        CFG_INITIAL_STATE = 2'd1,
        CFG_ERROR_EVENT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FN_DEFINE = 2'd0,
        FN_EVENT  = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_TAKEN       = 3'd0,
        ST_ERROR_TAKEN = 3'd1,
        ST_UNHANDLED   = 3'd2,
        ST_DEFINED     = 3'd3,
        ST_FULL        = 3'd4,
        ST_CLEARED     = 3'd5
    } t_status;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] src;
        logic [EVENT_W-1:0] evt;
        logic [STATE_W-1:0] dst;
        logic [ACT_W-1:0]   act;
    } t_entry;

    typedef struct packed {
        logic load;
        logic load_def;
        logic rem_start;
        logic walk_start;
        logic walk;
        logic free_mode;
        logic set_err;
        logic write;
        logic take;
        logic clr_step;
        logic reload;
    } t_cmd;

    typedef struct packed {
        logic rem_done;
        logic hit;
        logic miss;
        logic clr_last;
    } t_sts;

endpackage

>>> rtl/htfe_in_if.sv
// Input item channel: valid/ready handshake with the item fields.
interface htfe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] src_state;
    logic [7:0] event_id;
    logic [7:0] dest_state;
    logic [5:0] handler_id;

    modport source (output valid, func, src_state, event_id, dest_state, handler_id,
                    input ready);
    modport sink   (input valid, func, src_state, event_id, dest_state, handler_id,
                    output ready);
endinterface

>>> rtl/htfe_out_if.sv
// Result item channel: valid/ready handshake with the result fields.
interface htfe_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [5:0] slot;
    logic [5:0] action_id;
    logic [7:0] state_now;

    modport source (output valid, status, slot, action_id, state_now, input ready);
    modport sink   (input valid, status, slot, action_id, state_now, output ready);
endinterface

>>> rtl/htfe_rem.sv
// Bit-serial remainder unit: home slot of a 16-bit key modulo the live table size.
module htfe_rem #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [htfe_pkg::KEY_W-1:0]          i_key,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    i_mod,
    output logic                                o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_rem
);
    import htfe_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    logic [REM_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [NW-1:0]        r_rem;
    logic [KEY_W-1:0]     r_key;
    logic [NW:0]          w_trial;
    logic [NW:0]          w_diff;

    assign w_trial = {r_rem, r_key[KEY_W-1]};
    assign w_diff  = w_trial - {1'b0, i_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == REM_CNT_W'(1));
            if (i_start) begin
                r_cnt <= REM_CNT_W'(KEY_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // one key bit per cycle: shift in, subtract the modulus when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_key <= i_key;
        end else if (r_cnt != '0) begin
            r_rem <= (w_trial >= {1'b0, i_mod}) ? w_diff[NW-1:0] : w_trial[NW-1:0];
            r_key <= r_key << 1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];
endmodule

>>> rtl/htfe_dp.sv
// Datapath: transition memory, probe walker, key registers and current state.
module htfe_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  htfe_pkg::t_cmd                     i_cmd,
    output htfe_pkg::t_sts                     o_sts,
    input  logic [htfe_pkg::STATE_W-1:0]       i_src_state,
    input  logic [htfe_pkg::EVENT_W-1:0]       i_event_id,
    input  logic [htfe_pkg::STATE_W-1:0]       i_dest_state,
    input  logic [htfe_pkg::ACT_W-1:0]         i_handler_id,
    input  logic [htfe_pkg::SIZE_W-1:0]        i_table_size,
    input  logic [htfe_pkg::STATE_W-1:0]       i_initial_state,
    input  logic [htfe_pkg::EVENT_W-1:0]       i_error_event,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_slot,
    output logic [htfe_pkg::ACT_W-1:0]         o_action,
    output logic [htfe_pkg::STATE_W-1:0]       o_state
);
    import htfe_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;

    t_entry             r_mem [TABLE_DEPTH];
    t_entry             r_rd_data;
    logic [AW-1:0]      r_rd_slot;
    logic               r_rd_vld;
    logic [AW-1:0]      r_pslot;
    logic [NW-1:0]      r_pcnt;
    logic [AW-1:0]      r_clr_idx;
    logic [STATE_W-1:0] r_cur;
    logic [STATE_W-1:0] r_key_src;
    logic [EVENT_W-1:0] r_key_evt;
    logic [STATE_W-1:0] r_dst;
    logic [ACT_W-1:0]   r_act;

    logic [NW-1:0]      w_n;
    logic [CW-1:0]      w_size_ext;
    logic [AW-1:0]      w_home;
    logic               w_rem_done;
    logic               w_issue;
    logic [NW-1:0]      w_pslot_inc;
    logic [AW-1:0]      w_next;
    logic               w_match;
    logic               w_clr_last;

    // clamp the configured size into 1..TABLE_DEPTH
    assign w_size_ext = CW'(i_table_size);
    always_comb begin
        priority if (i_table_size == '0) begin
            w_n = NW'(1);
        end else if (w_size_ext > CW'(TABLE_DEPTH)) begin
            w_n = NW'(TABLE_DEPTH);
        end else begin
            w_n = w_size_ext[NW-1:0];
        end
    end

    htfe_rem #(.TABLE_DEPTH(TABLE_DEPTH)) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.rem_start),
        .i_key   ({r_key_evt, r_key_src}),
        .i_mod   (w_n),
        .o_done  (w_rem_done),
        .o_rem   (w_home)
    );

    assign w_issue     = (r_pcnt != w_n);
    assign w_pslot_inc = NW'(r_pslot) + NW'(1);
    assign w_next      = (w_pslot_inc == w_n) ? '0 : w_pslot_inc[AW-1:0];
    assign w_clr_last  = (r_clr_idx == AW'(TABLE_DEPTH - 1));

    always_comb begin
        if (i_cmd.free_mode) begin
            w_match = r_rd_vld && !r_rd_data.valid;
        end else begin
            w_match = r_rd_vld && r_rd_data.valid && (r_rd_data.src == r_key_src)
                      && (r_rd_data.evt == r_key_evt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= CFG_INIT_RST;
            r_rd_vld  <= 1'b0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.reload) begin
                r_cur <= i_initial_state;
            end else if (i_cmd.take) begin
                r_cur <= r_rd_data.dst;
            end
            if (i_cmd.walk_start) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.walk) begin
                r_rd_vld <= w_issue;
            end
            if (i_cmd.clr_step) begin
                r_clr_idx <= w_clr_last ? '0 : r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_src <= i_cmd.load_def ? i_src_state : r_cur;
            r_key_evt <= i_event_id;
            r_dst     <= i_dest_state;
            r_act     <= i_handler_id;
        end else if (i_cmd.set_err) begin
            r_key_evt <= i_error_event;
        end
        if (i_cmd.walk_start) begin
            r_pslot <= w_home;
            r_pcnt  <= '0;
        end else if (i_cmd.walk && w_issue) begin
            r_pslot <= w_next;
            r_pcnt  <= r_pcnt + 1'b1;
        end
    end

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[r_rd_slot] <= '{valid: 1'b1, src: r_key_src, evt: r_key_evt,
                                  dst: r_dst, act: r_act};
        end else if (i_cmd.clr_step) begin
            r_mem[r_clr_idx] <= '0;
        end
        if (i_cmd.walk && w_issue) begin
            r_rd_data <= r_mem[r_pslot];
            r_rd_slot <= r_pslot;
        end
    end

    assign o_sts.rem_done = w_rem_done;
    assign o_sts.hit      = w_match;
    assign o_sts.miss     = !r_rd_vld && (r_pcnt == w_n);
    assign o_sts.clr_last = w_clr_last;

    assign o_slot   = r_rd_slot;
    assign o_action = r_rd_data.act;
    assign o_state  = r_cur;
endmodule

>>> rtl/htfe_ctrl.sv
// Controller: sequences hashing, probe walks, table sweeps and result hand-off.
module htfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_func,
    input  logic              i_out_free,
    input  htfe_pkg::t_sts    i_sts,
    output logic              o_in_ready,
    output logic              o_push,
    output htfe_pkg::t_status o_status,
    output htfe_pkg::t_cmd    o_cmd
);
    import htfe_pkg::*;

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_START  = 7'b0000100,
        S_HASH   = 7'b0001000,
        S_WALK   = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state  r_state, n_state;
    t_func   r_func, n_func;
    logic    r_second, n_second;
    t_status r_status, n_status;

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_second   = r_second;
        n_status   = r_status;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        o_push     = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.load_def = (i_func == FN_DEFINE);
                    n_second       = 1'b0;
                    n_func         = t_func'(i_func);
                    unique case (i_func)
                        FN_DEFINE, FN_EVENT: n_state = S_START;
                        FN_CLEAR:            n_state = S_CLEAR;
                        default:             n_state = S_IDLE;   // drop unused code
                    endcase
                end
            end
            S_START: begin
                o_cmd.rem_start = 1'b1;
                n_state         = S_HASH;
            end
            S_HASH: begin
                if (i_sts.rem_done) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.free_mode = (r_func == FN_DEFINE);
                o_cmd.walk      = !i_sts.hit;
                if (i_sts.hit) begin
                    n_state = S_RESULT;
                    if (r_func == FN_DEFINE) begin
                        o_cmd.write = 1'b1;
                        n_status    = ST_DEFINED;
                    end else begin
                        o_cmd.take = 1'b1;
                        n_status   = r_second ? ST_ERROR_TAKEN : ST_TAKEN;
                    end
                end else if (i_sts.miss) begin
                    priority if (r_func == FN_DEFINE) begin
                        n_status = ST_FULL;
                        n_state  = S_RESULT;
                    end else if (!r_second) begin
                        o_cmd.set_err = 1'b1;
                        n_second      = 1'b1;
                        n_state       = S_START;
                    end else begin
                        n_status = ST_UNHANDLED;
                        n_state  = S_RESULT;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.reload = 1'b1;
                    n_status     = ST_CLEARED;
                    n_state      = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_func   <= FN_DEFINE;
            r_second <= 1'b0;
            r_status <= ST_TAKEN;
        end else begin
            r_state  <= n_state;
            r_func   <= n_func;
            r_second <= n_second;
            r_status <= n_status;
        end
    end

    assign o_status = r_status;
endmodule

>>> rtl/hashed_transition_fsm_engine_core.sv
// Hashed transition state machine engine: top level with config and result registers.
//
// Table-driven state machine whose transitions sit in an open-addressed hash
// table of TABLE_DEPTH entries. Each item (define, event or clear) gives one
// result; the unused function code is taken and dropped with no result.
// The home slot is ((event * 256) + state) mod n, where n is table_size clamped
// to 1..TABLE_DEPTH, found by a 16-step bit-serial remainder unit. A probe walk
// then reads one slot per cycle through the single read port of the table
// memory, up to n slots; an event that falls back to the error event hashes and
// walks a second time. A clear item sweeps the whole memory, one entry per
// cycle. After reset the same sweep runs with input ready held low; config
// writes are taken throughout. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted. Config
// writes land at once and are meant to happen only while the block is idle; a
// new initial_state takes effect at the next clear item.
module hashed_transition_fsm_engine_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    htfe_in_if.sink                             i_in,
    htfe_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [htfe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [htfe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import htfe_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [SIZE_W-1:0]  r_cfg_size;
    logic [STATE_W-1:0] r_cfg_init;
    logic [EVENT_W-1:0] r_cfg_err;

    logic               r_ovalid;
    t_status            r_ostatus;
    logic [SLOT_W-1:0]  r_oslot;
    logic [ACT_W-1:0]   r_oact;
    logic [STATE_W-1:0] r_ostate;

    t_cmd               w_cmd;
    t_sts               w_sts;
    t_status            w_status;
    logic               w_push;
    logic               w_out_free;
    logic [AW-1:0]      w_dp_slot;
    logic [ACT_W-1:0]   w_dp_act;
    logic [STATE_W-1:0] w_dp_state;
    logic               w_has_slot;
    logic               w_has_act;

    // config registers: write-only, index beyond the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size <= CFG_SIZE_RST;
            r_cfg_init <= CFG_INIT_RST;
            r_cfg_err  <= CFG_ERR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TABLE_SIZE:    r_cfg_size <= i_cfg_data[SIZE_W-1:0];
                CFG_INITIAL_STATE: r_cfg_init <= i_cfg_data[STATE_W-1:0];
                CFG_ERROR_EVENT:   r_cfg_err  <= i_cfg_data[EVENT_W-1:0];
                default: ;
            endcase
        end
    end

    htfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_func     (i_in.func),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_push     (w_push),
        .o_status   (w_status),
        .o_cmd      (w_cmd)
    );

    htfe_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_src_state     (i_in.src_state),
        .i_event_id      (i_in.event_id),
        .i_dest_state    (i_in.dest_state),
        .i_handler_id    (i_in.handler_id),
        .i_table_size    (r_cfg_size),
        .i_initial_state (r_cfg_init),
        .i_error_event   (r_cfg_err),
        .o_slot          (w_dp_slot),
        .o_action        (w_dp_act),
        .o_state         (w_dp_state)
    );

    // slot only for a write or a match, handler only for a transition taken
    assign w_has_act  = (w_status == ST_TAKEN) || (w_status == ST_ERROR_TAKEN);
    assign w_has_slot = w_has_act || (w_status == ST_DEFINED);
    assign w_out_free = !r_ovalid || o_out.ready;

    // output register: load when the controller hands off, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_push) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ostatus <= w_status;
            r_oslot   <= w_has_slot ? SLOT_W'(w_dp_slot) : '0;
            r_oact    <= w_has_act ? w_dp_act : '0;
            r_ostate  <= w_dp_state;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.status    = r_ostatus;
    assign o_out.slot      = r_oslot;
    assign o_out.action_id = r_oact;
    assign o_out.state_now = r_ostate;

`ifndef SYNTHESIS
    // results without a transition or write carry no slot and no handler
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_FULL || o_out.status == ST_UNHANDLED ||
                        o_out.status == ST_CLEARED)
        |-> (o_out.slot == '0) && (o_out.action_id == '0))
        else $error("slot or handler set on a result without a transition");

    // a real item keeps the engine busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready &&
        (i_in.func == FN_DEFINE || i_in.func == FN_EVENT || i_in.func == FN_CLEAR)
        |=> !i_in.ready)
        else $error("input accepted again while an item is in work");

    // a clear restarts from the configured initial state
    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_CLEARED) |-> (o_out.state_now == r_cfg_init))
        else $error("cleared result does not show the initial state");
`endif
endmodule
